// File: src/form_query_string_decoder_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the form query string decoder
// Shared forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FORM_QUERY_STRING_DECODER_TOP_MACROS_SVH
`define FORM_QUERY_STRING_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FQSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FQSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/fqsd_pkg.sv
// ----------------------------------------------------------------------------
// Form query string decoder package
// Payload types, character constants and the escape sequencing codes.
// ----------------------------------------------------------------------------
package fqsd_pkg;

  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
  localparam logic [7:0] CHAR_AMP     = 8'h26;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  typedef enum logic [1:0] {
    ESC_IDLE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_step_t;

  typedef struct packed {
    logic [7:0] raw_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] decoded_byte;
    logic       in_value;
    logic       key_end;
    logic       pair_done;
    logic       pair_dropped;
    logic       escape_error;
  } out_item_t;

  // A raw byte after classification by the front part.
  typedef struct packed {
    logic [7:0] raw_byte;
    logic       is_last;
    logic       is_equals;
    logic       is_amp;
    logic       is_plus;
    logic       is_percent;
    logic       hex_ok;
    logic [3:0] hex_value;
  } class_item_t;

  // Handshake between the front queue and the back part.
  typedef struct packed {
    logic        empty;
    class_item_t item;
  } front_status_t;

endpackage

// File: src/fqsd_fifo.sv
// ----------------------------------------------------------------------------
// Small flop-based queue
// First-in first-out buffer with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module fqsd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// File: src/fqsd_front.sv
// ----------------------------------------------------------------------------
// Decoder front part
// Accepts raw bytes, classifies them and queues them for the back part.
// ----------------------------------------------------------------------------
module fqsd_front
  import fqsd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  in_item_t      item,
  output logic          full,
  input  logic          back_pop,
  output front_status_t status
);

  class_item_t cls;

  // Hex digit decode for either letter case.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  always_comb begin
    cls.raw_byte   = item.raw_byte;
    cls.is_last    = item.is_last;
    cls.is_equals  = (item.raw_byte == CHAR_EQUALS);
    cls.is_amp     = (item.raw_byte == CHAR_AMP);
    cls.is_plus    = (item.raw_byte == CHAR_PLUS);
    cls.is_percent = (item.raw_byte == CHAR_PERCENT);
    {cls.hex_ok, cls.hex_value} = hex_decode(item.raw_byte);
  end

  fqsd_fifo #(
    .WIDTH($bits(class_item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cls),
    .full  (full),
    .pop   (back_pop),
    .rdata (status.item),
    .empty (status.empty)
  );

endmodule

// File: src/fqsd_back.sv
// ----------------------------------------------------------------------------
// Decoder back part
// Runs the key/value and escape state and queues one result per byte.
// ----------------------------------------------------------------------------
module fqsd_back
  import fqsd_pkg::*;
#(
  parameter int OUT_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  front_status_t status,
  output logic          back_pop,
  input  logic          pop,
  output out_item_t     result,
  output logic          empty
);

  logic        value_phase, value_phase_next;
  esc_step_t   escape_step, escape_step_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic        token_suppressed, token_suppressed_next;
  logic        out_full;
  logic        term;
  out_item_t   res;
  class_item_t c;

  assign c        = status.item;
  assign back_pop = !status.empty && !out_full;

  always_comb begin
    value_phase_next      = value_phase;
    escape_step_next      = escape_step;
    high_nibble_next      = high_nibble;
    token_suppressed_next = token_suppressed;
    res                   = '0;
    res.in_value          = value_phase;
    term = value_phase ? c.is_amp : c.is_equals;

    if (term) begin
      res.escape_error      = (escape_step != ESC_IDLE) && !token_suppressed;
      escape_step_next      = ESC_IDLE;
      high_nibble_next      = 4'd0;
      token_suppressed_next = 1'b0;
      if (!value_phase) begin
        res.key_end      = 1'b1;
        value_phase_next = 1'b1;
        res.pair_done    = c.is_last;
      end else begin
        res.pair_done    = 1'b1;
        value_phase_next = 1'b0;
      end
    end else begin
      if (!token_suppressed) begin
        unique case (escape_step)
          ESC_HIGH, ESC_LOW: begin
            if (!c.hex_ok) begin
              res.escape_error      = 1'b1;
              token_suppressed_next = 1'b1;
              escape_step_next      = ESC_IDLE;
              high_nibble_next      = 4'd0;
            end else if (escape_step == ESC_HIGH) begin
              high_nibble_next = c.hex_value;
              escape_step_next = ESC_LOW;
            end else begin
              res.byte_valid   = 1'b1;
              res.decoded_byte = {high_nibble, c.hex_value};
              escape_step_next = ESC_IDLE;
              high_nibble_next = 4'd0;
            end
          end
          ESC_IDLE: begin
            if (c.is_plus) begin
              res.byte_valid   = 1'b1;
              res.decoded_byte = CHAR_SPACE;
            end else if (c.is_percent) begin
              escape_step_next = ESC_HIGH;
            end else begin
              res.byte_valid   = 1'b1;
              res.decoded_byte = c.raw_byte;
            end
          end
          default: begin
            escape_step_next = ESC_IDLE;
          end
        endcase
      end
      if (c.is_last) begin
        if (escape_step_next != ESC_IDLE) begin
          res.escape_error = 1'b1;
        end
        if (value_phase) begin
          res.pair_done = 1'b1;
        end else begin
          res.pair_dropped = 1'b1;
        end
      end
    end

    // The final byte of a string returns all state to its reset values.
    if (c.is_last) begin
      value_phase_next      = 1'b0;
      escape_step_next      = ESC_IDLE;
      high_nibble_next      = 4'd0;
      token_suppressed_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value_phase      <= 1'b0;
      escape_step      <= ESC_IDLE;
      high_nibble      <= 4'd0;
      token_suppressed <= 1'b0;
    end else if (back_pop) begin
      value_phase      <= value_phase_next;
      escape_step      <= escape_step_next;
      high_nibble      <= high_nibble_next;
      token_suppressed <= token_suppressed_next;
    end
  end

  fqsd_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (back_pop),
    .wdata (res),
    .full  (out_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

// File: src/form_query_string_decoder_top.sv
// A byte passes the front queue and then the result queue before its result shows.
// Throughput: one byte per cycle while the result queue has room, set by the back part.
// The front queue and the result queue let either side stall without losing a transaction.
// Reset: synchronous, active high; it empties both queues and returns to key phase.
// ----------------------------------------------------------------------------
// Form query string decoder top level
// Streaming decoder for key=value&key=value strings, one result per raw byte.
// ----------------------------------------------------------------------------
`include "form_query_string_decoder_top_macros.svh"

module form_query_string_decoder_top
  import fqsd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4,
  parameter int OUT_DEPTH   = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  in_item_t  item,
  output logic      full,
  input  logic      pop,
  output out_item_t result,
  output logic      empty
);

  // The front part classifies each raw byte (delimiters, plus, percent and
  // hex digit value) and holds it in a short queue. The back part pops one
  // classified byte per cycle whenever its result queue has room, applies
  // the key/value phase and escape state, and pushes exactly one result.

  front_status_t front_status;
  logic          back_pop;

  fqsd_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .back_pop (back_pop),
    .status   (front_status)
  );

  fqsd_back #(
    .OUT_DEPTH(OUT_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .status   (front_status),
    .back_pop (back_pop),
    .pop      (pop),
    .result   (result),
    .empty    (empty)
  );

  // An escape error never comes with an emitted character.
  `FQSD_ASSERT_NOW(a_err_no_byte, !empty && result.escape_error, !result.byte_valid, "error with byte")
  // A key close is always reported in key phase and never emits a character.
  `FQSD_ASSERT_NOW(a_key_end_phase, !empty && result.key_end, !result.in_value && !result.byte_valid, "bad key end")
  // A dropped pair is a key-phase result and never also a completed pair.
  `FQSD_ASSERT_NOW(a_drop_phase, !empty && result.pair_dropped, !result.in_value && !result.pair_done, "bad drop")
  // The back part only moves a transaction when the front queue holds one.
  `FQSD_ASSERT_NOW(a_pop_has_data, back_pop, !front_status.empty, "pop from empty queue")
  // A transaction into an empty pipeline is not visible in the same cycle.
  `FQSD_ASSERT_NEXT(a_queue_fill, push && !full, !front_status.empty || back_pop || !empty, "lost transaction")

endmodule
